@@ hdl/dipf_pkg.sv @@
// Shared types, constants and register codes for the depth isolated point filter.
package dipf_pkg;

    localparam int ROWS_DEF  = 16;
    localparam int REACH_DEF = 4;
    localparam int DEPTH_W   = 16;
    localparam int NEED_W    = 4;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic [DEPTH_W-1:0] FAR_KEEP_RST = 16'd800;
    localparam logic [DEPTH_W-1:0] NEAR_TOP_RST = 16'd200;
    localparam logic [DEPTH_W-1:0] MID_TOP_RST  = 16'd500;
    localparam logic [DEPTH_W-1:0] NEAR_TOL_RST = 16'd20;
    localparam logic [DEPTH_W-1:0] MID_TOL_RST  = 16'd50;
    localparam logic [DEPTH_W-1:0] FAR_TOL_RST  = 16'd100;
    localparam logic [NEED_W-1:0]  NEAR_NEED_RST = 4'd3;
    localparam logic [NEED_W-1:0]  MID_NEED_RST  = 4'd2;
    localparam logic [NEED_W-1:0]  FAR_NEED      = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAR_KEEP  = 3'd0,
        CFG_NEAR_TOP  = 3'd1,
        CFG_MID_TOP   = 3'd2,
        CFG_NEAR_TOL  = 3'd3,
        CFG_MID_TOL   = 3'd4,
        CFG_FAR_TOL   = 3'd5,
        CFG_NEAR_NEED = 3'd6,
        CFG_MID_NEED  = 3'd7
    } cfg_idx_t;

    // input item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_EOF    = 1'b1;

    typedef struct packed {
        logic               op;
        logic [DEPTH_W-1:0] depth_cm;
    } in_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_out;
        logic               keep;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] far_keep_limit;
        logic [DEPTH_W-1:0] near_band_top;
        logic [DEPTH_W-1:0] mid_band_top;
        logic [DEPTH_W-1:0] near_tolerance;
        logic [DEPTH_W-1:0] mid_tolerance;
        logic [DEPTH_W-1:0] far_tolerance;
        logic [NEED_W-1:0]  near_needed;
        logic [NEED_W-1:0]  mid_needed;
    } cfg_t;

    // control that rides along with a pixel sent for classification
    typedef struct packed {
        logic last;
        logic up_ok;
        logic down_ok;
    } judge_ctl_t;

endpackage

@@ hdl/dipf_cell.sv @@
// One window cell: a column of ROWS depth samples shifting toward its left neighbor.
module dipf_cell
    import dipf_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic                          clear,
    input  logic [DEPTH_W-1:0]            din,
    output logic [ROWS-1:0][DEPTH_W-1:0]  col
);

    logic [ROWS-1:0][DEPTH_W-1:0] col_reg;
    logic [ROWS-1:0][DEPTH_W-1:0] col_next;

    // entry 0 is the oldest; new data enters at the top
    always_comb
    begin
        col_next = col_reg;
        if (clear)
        begin
            col_next = '0;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < ROWS - 1; i++)
            begin
                col_next[i] = col_reg[i+1];
            end
            col_next[ROWS-1] = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col = col_reg;

endmodule

@@ hdl/dipf_judge.sv @@
// Two-stage classifier: neighbor match bits, then match count against the band threshold.
module dipf_judge
    import dipf_pkg::*;
#(
    parameter int REACH = REACH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                req_valid,
    output logic                req_ready,
    input  judge_ctl_t          req_ctl,
    input  logic [DEPTH_W-1:0]  center,
    input  logic [DEPTH_W-1:0]  horiz [2*REACH],
    input  logic [DEPTH_W-1:0]  up,
    input  logic [DEPTH_W-1:0]  down,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data
);

    localparam int NM     = 2 * REACH + 2;
    localparam int CNT_W  = $clog2(NM + 1);
    localparam int CMP_W  = (CNT_W > NEED_W) ? CNT_W : NEED_W;

    function automatic logic is_match(input logic [DEPTH_W-1:0] d,
                                      input logic [DEPTH_W-1:0] n,
                                      input logic [DEPTH_W-1:0] tol);
        logic [DEPTH_W-1:0] diff;
        diff = (d > n) ? (d - n) : (n - d);
        return (n != '0) && (diff < tol);
    endfunction

    // stage 1 registers
    logic                s1_valid_reg;
    logic [DEPTH_W-1:0]  s1_depth_reg;
    logic                s1_force_reg;
    logic [NEED_W-1:0]   s1_need_reg;
    logic [NM-1:0]       s1_match_reg;
    logic                s1_last_reg;

    // output stage registers
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                adv2;
    logic                s1_ready;
    logic [DEPTH_W-1:0]  tol;
    logic [NEED_W-1:0]   need;
    logic [NM-1:0]       match;
    logic                force_keep;
    logic [CNT_W-1:0]    count;

    assign adv2      = !out_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || adv2;
    assign req_ready = s1_ready;

    // band select; near is tested first
    always_comb
    begin
        force_keep = (center > cfg.far_keep_limit) || (center == '0);
        if (center <= cfg.near_band_top)
        begin
            tol  = cfg.near_tolerance;
            need = cfg.near_needed;
        end
        else if (center <= cfg.mid_band_top)
        begin
            tol  = cfg.mid_tolerance;
            need = cfg.mid_needed;
        end
        else
        begin
            tol  = cfg.far_tolerance;
            need = FAR_NEED;
        end
    end

    // per-neighbor match bits
    always_comb
    begin
        for (int k = 0; k < 2 * REACH; k++)
        begin
            match[k] = is_match(center, horiz[k], tol);
        end
        match[NM-2] = req_ctl.up_ok && is_match(center, up, tol);
        match[NM-1] = req_ctl.down_ok && is_match(center, down, tol);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req_valid)
        begin
            s1_depth_reg <= center;
            s1_force_reg <= force_keep;
            s1_need_reg  <= need;
            s1_match_reg <= match;
            s1_last_reg  <= req_ctl.last;
        end
    end

    // count matches
    always_comb
    begin
        count = '0;
        for (int i = 0; i < NM; i++)
        begin
            count = count + CNT_W'(s1_match_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            out_data_reg.depth_out <= s1_depth_reg;
            out_data_reg.keep      <= s1_force_reg ||
                                      (CMP_W'(count) >= CMP_W'(s1_need_reg));
            out_data_reg.last      <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/depth_isolated_point_filter.sv @@
// Top level: sample window as a chain of column cells, drain sequencer, classifier.
// Throughput: one depth sample per cycle when not draining and the judge is ready; a pixel's
// result goes through judge stage 1 and output registers after the transfer of the sample
// REACH columns later in its row. End of frame: drain shifts feed zeros into the cell chain,
// no input taken meanwhile; results leave through the same pipeline, one per cycle while out_ready holds.
// Reset: window cells, row and pending counters clear to zero, registers to defaults.
module depth_isolated_point_filter
    import dipf_pkg::*;
#(
    parameter int ROWS  = ROWS_DEF,
    parameter int REACH = REACH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DEPTH_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    localparam int NCOL  = 2 * REACH + 1;
    localparam int LAG   = REACH * ROWS;
    localparam int CNT_W = $clog2(LAG + 1);
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [CNT_W-1:0] LAG_C    = CNT_W'(LAG);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    cfg_t                         cfg_reg;
    logic                         draining_reg;
    logic [CNT_W-1:0]             drain_idx_reg;
    logic [CNT_W-1:0]             pend_reg;
    logic [ROW_W-1:0]             row_reg;

    logic [ROWS-1:0][DEPTH_W-1:0] col [NCOL];
    logic                         jready;
    logic                         in_xfer;
    logic                         sample_xfer;
    logic                         eof_xfer;
    logic                         drain_step;
    logic                         drain_end;
    logic                         shift_en;
    logic                         clear;
    logic [DEPTH_W-1:0]           shift_din;
    logic                         req_valid;
    judge_ctl_t                   req_ctl;
    logic [DEPTH_W-1:0]           horiz [2*REACH];
    logic [ROW_W-1:0]             row_inc;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.far_keep_limit <= FAR_KEEP_RST;
            cfg_reg.near_band_top  <= NEAR_TOP_RST;
            cfg_reg.mid_band_top   <= MID_TOP_RST;
            cfg_reg.near_tolerance <= NEAR_TOL_RST;
            cfg_reg.mid_tolerance  <= MID_TOL_RST;
            cfg_reg.far_tolerance  <= FAR_TOL_RST;
            cfg_reg.near_needed    <= NEAR_NEED_RST;
            cfg_reg.mid_needed     <= MID_NEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FAR_KEEP:  cfg_reg.far_keep_limit <= cfg_data;
                CFG_NEAR_TOP:  cfg_reg.near_band_top  <= cfg_data;
                CFG_MID_TOP:   cfg_reg.mid_band_top   <= cfg_data;
                CFG_NEAR_TOL:  cfg_reg.near_tolerance <= cfg_data;
                CFG_MID_TOL:   cfg_reg.mid_tolerance  <= cfg_data;
                CFG_FAR_TOL:   cfg_reg.far_tolerance  <= cfg_data;
                CFG_NEAR_NEED: cfg_reg.near_needed    <= cfg_data[NEED_W-1:0];
                CFG_MID_NEED:  cfg_reg.mid_needed     <= cfg_data[NEED_W-1:0];
                default:       ;
            endcase
        end
    end

    // handshake and step decode
    assign in_ready    = !draining_reg && jready;
    assign in_xfer     = in_valid && in_ready;
    assign sample_xfer = in_xfer && (in_data.op == OP_SAMPLE);
    assign eof_xfer    = in_xfer && (in_data.op == OP_EOF);
    assign drain_step  = draining_reg && jready;
    assign drain_end   = drain_step && (drain_idx_reg == LAG_C);
    assign shift_en    = sample_xfer || drain_step;
    assign clear       = drain_end;
    assign shift_din   = draining_reg ? '0 : in_data.depth_cm;
    assign row_inc     = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;

    // a pixel is emitted once its row's sample REACH columns later arrives
    assign req_valid = (sample_xfer && (pend_reg == LAG_C)) ||
                       (drain_step && (drain_idx_reg > (LAG_C - pend_reg)));
    assign req_ctl.last    = drain_end;
    assign req_ctl.up_ok   = (row_reg != '0);
    assign req_ctl.down_ok = (row_reg != LAST_ROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg  <= 1'b0;
            drain_idx_reg <= '0;
            pend_reg      <= '0;
            row_reg       <= '0;
        end
        else if (eof_xfer)
        begin
            draining_reg  <= 1'b1;
            drain_idx_reg <= CNT_W'(1);
        end
        else if (drain_end)
        begin
            draining_reg  <= 1'b0;
            drain_idx_reg <= '0;
            pend_reg      <= '0;
            row_reg       <= '0;
        end
        else if (drain_step)
        begin
            drain_idx_reg <= drain_idx_reg + 1'b1;
            row_reg       <= row_inc;
        end
        else if (sample_xfer)
        begin
            row_reg <= row_inc;
            if (pend_reg != LAG_C)
            begin
                pend_reg <= pend_reg + 1'b1;
            end
        end
    end

    // column cell chain; the last cell takes the incoming sample
    for (genvar c = 0; c < NCOL; c++)
    begin : g_cell
        logic [DEPTH_W-1:0] cell_din;
        if (c == NCOL - 1)
        begin : g_tail
            assign cell_din = shift_din;
        end
        else
        begin : g_link
            assign cell_din = col[c+1][0];
        end
        dipf_cell #(
            .ROWS (ROWS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .clear    (clear),
            .din      (cell_din),
            .col      (col[c])
        );
    end

    // taps of the window as it stands after this shift
    always_comb
    begin
        for (int k = 1; k <= REACH; k++)
        begin
            horiz[2*k-2] = col[REACH+1-k][0];
            if (k == REACH)
            begin
                horiz[2*k-1] = shift_din;
            end
            else
            begin
                horiz[2*k-1] = col[REACH+1+k][0];
            end
        end
    end

    dipf_judge #(
        .REACH (REACH)
    ) u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (jready),
        .req_ctl   (req_ctl),
        .center    (col[REACH+1][0]),
        .horiz     (horiz),
        .up        (col[REACH][ROWS-1]),
        .down      (col[REACH+1][1]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
